FILE: hdl/keypad_code_lock_controller_core_defines.svh
// Assertion macros shared by the code lock RTL.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef KEYPAD_CODE_LOCK_CONTROLLER_CORE_DEFINES_SVH
`define KEYPAD_CODE_LOCK_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define KCL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check that cons holds in the cycle after ante.
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define KCL_ASSERT_NOW(lbl, ante, cons, msg)
`define KCL_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

FILE: hdl/kcl_pkg.sv
// Shared types, codes and constants of the keypad code lock.
// Used by every module of the block; no dependencies.
package kcl_pkg;

  localparam int CODE_LENGTH_DEF = 4;
  localparam int TIMER_WIDTH_DEF = 16;

  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int TICKS_W     = 16;

  // register indexes on the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_MASTER_CODE   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_WRONG_LIMIT   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LOCKOUT_TICKS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_OPEN_TICKS    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_IR_HOLD_TICKS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_SLEEP_TICKS   = 3'd5;

  localparam logic [7:0]         RST_MASTER_CODE   = 8'd228;
  localparam logic [3:0]         RST_WRONG_LIMIT   = 4'd3;
  localparam logic [TICKS_W-1:0] RST_LOCKOUT_TICKS = 16'd60000;
  localparam logic [TICKS_W-1:0] RST_OPEN_TICKS    = 16'd30000;
  localparam logic [TICKS_W-1:0] RST_IR_HOLD_TICKS = 16'd1500;
  localparam logic [TICKS_W-1:0] RST_SLEEP_TICKS   = 16'd5000;

  localparam logic [1:0] MODE_LOCKED  = 2'd0;
  localparam logic [1:0] MODE_OPEN    = 2'd1;
  localparam logic [1:0] MODE_LOCKOUT = 2'd2;

  localparam logic [2:0] KEY_NONE      = 3'd0;
  localparam logic [2:0] KEY_DIGIT_LO  = 3'd1;
  localparam logic [2:0] KEY_DIGIT_HI  = 3'd4;
  localparam logic [2:0] KEY_ENTER     = 3'd5;

  localparam logic [2:0] EV_NONE        = 3'd0;
  localparam logic [2:0] EV_OPENED      = 3'd1;
  localparam logic [2:0] EV_WRONG_CODE  = 3'd2;
  localparam logic [2:0] EV_CLOSED      = 3'd3;
  localparam logic [2:0] EV_LOCKOUT_END = 3'd4;

  localparam logic [3:0] WRONG_COUNT_MAX = 4'd15;

  typedef struct packed {
    logic [2:0] key;
    logic       ir_blocked;
  } in_item_t;

  typedef struct packed {
    logic               door_open;
    logic               lockout_active;
    logic               display_on;
    logic [2:0]         digits_entered;
    logic [TICKS_W-1:0] remaining_ticks;
    logic [2:0]         event_res;
  } out_item_t;

  typedef struct packed {
    logic [7:0]         master_code;
    logic [3:0]         wrong_limit;
    logic [TICKS_W-1:0] lockout_ticks;
    logic [TICKS_W-1:0] open_ticks;
    logic [TICKS_W-1:0] ir_hold_ticks;
    logic [TICKS_W-1:0] sleep_ticks;
  } cfg_t;

  // Master digit at position pos; positions past the fourth read as zero.
  function automatic logic [1:0] master_digit(input logic [7:0] code, input int pos);
    logic [7:0] sh;
    sh = code >> (2 * pos);
    return sh[1:0];
  endfunction

endpackage

FILE: hdl/keypad_code_lock_controller_core.sv
// Channel  | Dir | Handshake             | Payload
// in_      | in  | in_valid / in_stall   | in_data   (kcl_pkg::in_item_t)
// out_     | out | out_valid / out_stall | out_data  (kcl_pkg::out_item_t)
// cfg_     | in  | cfg_we                | cfg_index, cfg_wdata
//
// One tick beat per cycle while out_stall is low: a beat sits in the input
// register and is evaluated by kcl_step on its way into the result register.
// The input register takes a new beat while a result waits on out_stall only if
// it is empty; a beat already in it is held there and stalls the input.
// Synchronous active-low reset: lock closed, counters and timers zero, display
// on, configuration at its defaults, both registers empty.
// Depends on kcl_pkg, kcl_cfg_regs, kcl_step and the defines header.
module keypad_code_lock_controller_core #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
  parameter int TIMER_WIDTH = kcl_pkg::TIMER_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  kcl_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output kcl_pkg::out_item_t              out_data,
  input  logic                            cfg_we,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import kcl_pkg::*;
`include "keypad_code_lock_controller_core_defines.svh"

  localparam int CW  = $clog2(CODE_LENGTH + 1);
  localparam int DIW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  cfg_t      cfg;
  logic      in_valid_r;
  in_item_t  in_data_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  out_item_t result;
  logic      out_free;
  logic      advance;
  logic      in_accept;

  logic [1:0]                  mode_r, mode_nxt;
  logic [CW-1:0]               digit_count_r, digit_count_nxt;
  logic [3:0]                  wrong_count_r, wrong_count_nxt;
  logic [TIMER_WIDTH-1:0]      period_timer_r, period_timer_nxt;
  logic [TIMER_WIDTH-1:0]      ir_hold_timer_r, ir_hold_timer_nxt;
  logic [TIMER_WIDTH-1:0]      idle_timer_r, idle_timer_nxt;
  logic                        awake_r, awake_nxt;
  logic [CODE_LENGTH-1:0][1:0] digits_r;
  logic                        digit_we;
  logic [DIW-1:0]              digit_idx;
  logic [1:0]                  digit_val;

  kcl_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  kcl_step #(
    .CODE_LENGTH (CODE_LENGTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_step (
    .item              (in_data_r),
    .cfg               (cfg),
    .mode              (mode_r),
    .digits            (digits_r),
    .digit_count       (digit_count_r),
    .wrong_count       (wrong_count_r),
    .period_timer      (period_timer_r),
    .ir_hold_timer     (ir_hold_timer_r),
    .idle_timer        (idle_timer_r),
    .awake             (awake_r),
    .mode_nxt          (mode_nxt),
    .digit_count_nxt   (digit_count_nxt),
    .wrong_count_nxt   (wrong_count_nxt),
    .period_timer_nxt  (period_timer_nxt),
    .ir_hold_timer_nxt (ir_hold_timer_nxt),
    .idle_timer_nxt    (idle_timer_nxt),
    .awake_nxt         (awake_nxt),
    .digit_we          (digit_we),
    .digit_idx         (digit_idx),
    .digit_val         (digit_val),
    .result            (result)
  );

  // advance the input beat when the result register is empty or draining
  assign out_free  = !out_valid_r || !out_stall;
  assign advance   = in_valid_r && out_free;
  assign in_stall  = in_valid_r && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      in_data_r <= in_data;
    end
    if (advance) begin
      out_data_r <= result;
    end
  end

  // lock state moves only with a beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r          <= MODE_LOCKED;
      digit_count_r   <= '0;
      wrong_count_r   <= '0;
      period_timer_r  <= '0;
      ir_hold_timer_r <= '0;
      idle_timer_r    <= '0;
      awake_r         <= 1'b1;
    end else if (advance) begin
      mode_r          <= mode_nxt;
      digit_count_r   <= digit_count_nxt;
      wrong_count_r   <= wrong_count_nxt;
      period_timer_r  <= period_timer_nxt;
      ir_hold_timer_r <= ir_hold_timer_nxt;
      idle_timer_r    <= idle_timer_nxt;
      awake_r         <= awake_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && digit_we) begin
      digits_r[digit_idx] <= digit_val;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `KCL_ASSERT_NEXT(a_advance_fills_out, advance, out_valid_r, "beat lost on the way out")
  `KCL_ASSERT_NEXT(a_stalled_out_held, out_valid_r && out_stall, out_valid_r,
                   "stalled result dropped")
  `KCL_ASSERT_NOW(a_count_bound, 1'b1, digit_count_r <= CW'(CODE_LENGTH),
                  "digit count overran")
  `KCL_ASSERT_NOW(a_opened_means_open, out_valid_r && out_data_r.event_res == EV_OPENED,
                  out_data_r.door_open, "opened without open door")
  `KCL_ASSERT_NEXT(a_idle_state_holds, !advance, $stable(period_timer_r),
                   "timer moved without a beat")

endmodule

FILE: hdl/kcl_cfg_regs.sv
// Configuration register file of the code lock.
// Depends on kcl_pkg for register indexes, reset values and cfg_t.
module kcl_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [kcl_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [kcl_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output kcl_pkg::cfg_t                    cfg
);
  import kcl_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_MASTER_CODE:   cfg_nxt.master_code   = cfg_wdata[7:0];
        REG_WRONG_LIMIT:   cfg_nxt.wrong_limit   = cfg_wdata[3:0];
        REG_LOCKOUT_TICKS: cfg_nxt.lockout_ticks = cfg_wdata[TICKS_W-1:0];
        REG_OPEN_TICKS:    cfg_nxt.open_ticks    = cfg_wdata[TICKS_W-1:0];
        REG_IR_HOLD_TICKS: cfg_nxt.ir_hold_ticks = cfg_wdata[TICKS_W-1:0];
        REG_SLEEP_TICKS:   cfg_nxt.sleep_ticks   = cfg_wdata[TICKS_W-1:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.master_code   <= RST_MASTER_CODE;
      cfg_r.wrong_limit   <= RST_WRONG_LIMIT;
      cfg_r.lockout_ticks <= RST_LOCKOUT_TICKS;
      cfg_r.open_ticks    <= RST_OPEN_TICKS;
      cfg_r.ir_hold_ticks <= RST_IR_HOLD_TICKS;
      cfg_r.sleep_ticks   <= RST_SLEEP_TICKS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: hdl/kcl_step.sv
// One-tick update of the code lock: next state and result beat from the
// current state, the registered input beat and the configuration.
// Depends on kcl_pkg.
module kcl_step #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF,
  parameter int TIMER_WIDTH = kcl_pkg::TIMER_WIDTH_DEF,
  localparam int CW  = $clog2(CODE_LENGTH + 1),
  localparam int DIW = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1
) (
  input  kcl_pkg::in_item_t                item,
  input  kcl_pkg::cfg_t                    cfg,
  input  logic [1:0]                       mode,
  input  logic [CODE_LENGTH-1:0][1:0]      digits,
  input  logic [CW-1:0]                    digit_count,
  input  logic [3:0]                       wrong_count,
  input  logic [TIMER_WIDTH-1:0]           period_timer,
  input  logic [TIMER_WIDTH-1:0]           ir_hold_timer,
  input  logic [TIMER_WIDTH-1:0]           idle_timer,
  input  logic                             awake,
  output logic [1:0]                       mode_nxt,
  output logic [CW-1:0]                    digit_count_nxt,
  output logic [3:0]                       wrong_count_nxt,
  output logic [TIMER_WIDTH-1:0]           period_timer_nxt,
  output logic [TIMER_WIDTH-1:0]           ir_hold_timer_nxt,
  output logic [TIMER_WIDTH-1:0]           idle_timer_nxt,
  output logic                             awake_nxt,
  output logic                             digit_we,
  output logic [DIW-1:0]                   digit_idx,
  output logic [1:0]                       digit_val,
  output kcl_pkg::out_item_t               result
);
  import kcl_pkg::*;

  // compare width wide enough for both timers and tick registers
  localparam int LW = (TIMER_WIDTH > TICKS_W) ? TIMER_WIDTH : TICKS_W;
  localparam logic [TIMER_WIDTH-1:0] TMAX = '1;

  logic [2:0]             key;
  logic                   match;
  logic [TIMER_WIDTH-1:0] open_load;
  logic [TIMER_WIDTH-1:0] lockout_load;
  logic [2:0]             ev;
  logic                   skip;
  logic [3:0]             wc_inc;

  // saturate a tick register into the timer range
  function automatic logic [TIMER_WIDTH-1:0] sat_load(input logic [TICKS_W-1:0] v);
    logic [LW-1:0] v_ext;
    v_ext = LW'(v);
    return (v_ext > LW'(TMAX)) ? TMAX : TIMER_WIDTH'(v_ext);
  endfunction

  function automatic logic [TIMER_WIDTH-1:0] sat_inc(input logic [TIMER_WIDTH-1:0] v);
    return (v == TMAX) ? v : v + 1'b1;
  endfunction

  assign key = (item.key > KEY_ENTER) ? KEY_NONE : item.key;
  assign open_load    = sat_load(cfg.open_ticks);
  assign lockout_load = sat_load(cfg.lockout_ticks);
  assign wc_inc = (wrong_count < WRONG_COUNT_MAX) ? wrong_count + 4'd1 : wrong_count;

  always_comb begin
    match = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (digits[i] != master_digit(cfg.master_code, i)) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    mode_nxt          = mode;
    digit_count_nxt   = digit_count;
    wrong_count_nxt   = wrong_count;
    period_timer_nxt  = period_timer;
    ir_hold_timer_nxt = ir_hold_timer;
    idle_timer_nxt    = idle_timer;
    awake_nxt         = awake;
    digit_we          = 1'b0;
    digit_idx         = digit_count[DIW-1:0];
    digit_val         = 2'(key - KEY_DIGIT_LO);
    ev                = EV_NONE;
    skip              = 1'b0;

    // lockout swallows the tick until its timer runs out
    if (mode == MODE_LOCKOUT) begin
      if (period_timer != '0) begin
        period_timer_nxt = period_timer - 1'b1;
        skip             = 1'b1;
      end else begin
        mode_nxt        = MODE_LOCKED;
        wrong_count_nxt = '0;
        ev              = EV_LOCKOUT_END;
      end
    end

    if (!skip) begin
      idle_timer_nxt = sat_inc(idle_timer);
      if (mode_nxt == MODE_LOCKED && awake && LW'(idle_timer_nxt) > LW'(cfg.sleep_ticks)) begin
        awake_nxt = 1'b0;
      end
      if (key != KEY_NONE || item.ir_blocked) begin
        idle_timer_nxt = '0;
        awake_nxt      = 1'b1;
      end

      if (mode_nxt == MODE_LOCKED) begin
        if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI && digit_count < CW'(CODE_LENGTH)) begin
          digit_we        = 1'b1;
          digit_count_nxt = digit_count + 1'b1;
        end else if (key == KEY_ENTER && digit_count == CW'(CODE_LENGTH)) begin
          if (match) begin
            mode_nxt          = MODE_OPEN;
            period_timer_nxt  = open_load;
            ir_hold_timer_nxt = '0;
            wrong_count_nxt   = '0;
            ev                = EV_OPENED;
          end else begin
            wrong_count_nxt = wc_inc;
            digit_count_nxt = '0;
            ev              = EV_WRONG_CODE;
            if (wc_inc >= cfg.wrong_limit) begin
              mode_nxt         = MODE_LOCKOUT;
              period_timer_nxt = lockout_load;
            end
          end
        end
      end else if (mode_nxt == MODE_OPEN) begin
        if (period_timer == '0) begin
          mode_nxt        = MODE_LOCKED;
          digit_count_nxt = '0;
          ev              = EV_CLOSED;
        end else begin
          period_timer_nxt = period_timer - 1'b1;
          if (item.ir_blocked) begin
            // close early once the beam has been blocked long enough
            if (LW'(ir_hold_timer) > LW'(cfg.ir_hold_ticks)) begin
              period_timer_nxt = '0;
            end
            ir_hold_timer_nxt = sat_inc(ir_hold_timer);
          end else begin
            ir_hold_timer_nxt = '0;
          end
        end
      end
    end
  end

  always_comb begin
    result.door_open       = (mode_nxt == MODE_OPEN);
    result.lockout_active  = (mode_nxt == MODE_LOCKOUT);
    result.display_on      = awake_nxt;
    result.digits_entered  = 3'(digit_count_nxt);
    result.remaining_ticks = (mode_nxt == MODE_OPEN || mode_nxt == MODE_LOCKOUT) ?
                             TICKS_W'(period_timer_nxt) : '0;
    result.event_res       = ev;
  end

endmodule

FILE: test/keypad_code_lock_checker.sv
// Scoreboard for the keypad code lock: mirrors lock state and settings, predicts
// the status beat of every accepted tick and compares each beat on the way out.
// Depends on kcl_pkg for beat types, register indexes, mode and event codes.
module keypad_code_lock_checker
  import kcl_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_data,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int unsigned            fail_count,
  output int unsigned            pending
);

  localparam int                 DIGITS       = CODE_LENGTH_DEF;
  localparam logic [TICKS_W-1:0] TICKS_MAX    = '1;
  localparam int unsigned        REPORT_LIMIT = 10;

  cfg_t               lock_cfg;
  logic [1:0]         lock_mode;
  logic [1:0]         code_entry [DIGITS];
  logic [2:0]         digit_cnt;
  logic [3:0]         wrong_cnt;
  logic [TICKS_W-1:0] period_left;
  logic [TICKS_W-1:0] ir_held;
  logic [TICKS_W-1:0] idle_for;
  logic               awake;
  out_item_t          status_due [$];
  out_item_t          due;

  function automatic logic [TICKS_W-1:0] sat_inc(input logic [TICKS_W-1:0] v);
    return (v == TICKS_MAX) ? v : v + 1'b1;
  endfunction

  // Advance the lock by one tick and return the status it reports.
  function automatic out_item_t lock_tick(input in_item_t beat);
    logic [2:0] key;
    logic       ir;
    logic [2:0] ev;
    logic       match;
    int         pos;
    out_item_t  st;
    key = (beat.key > KEY_ENTER) ? KEY_NONE : beat.key;
    ir  = beat.ir_blocked;
    ev  = EV_NONE;
    if (lock_mode == MODE_LOCKOUT && period_left != '0) begin
      // lockout swallows the whole tick
      period_left = period_left - 1'b1;
    end else begin
      if (lock_mode == MODE_LOCKOUT) begin
        lock_mode = MODE_LOCKED;
        wrong_cnt = '0;
        ev        = EV_LOCKOUT_END;
      end
      idle_for = sat_inc(idle_for);
      if (lock_mode == MODE_LOCKED && awake && idle_for > lock_cfg.sleep_ticks) begin
        awake = 1'b0;
      end
      if (key != KEY_NONE || ir) begin
        idle_for = '0;
        awake    = 1'b1;
      end
      if (lock_mode == MODE_LOCKED) begin
        if (key >= KEY_DIGIT_LO && key <= KEY_DIGIT_HI && digit_cnt < DIGITS) begin
          code_entry[digit_cnt] = 2'(key - KEY_DIGIT_LO);
          digit_cnt             = digit_cnt + 1'b1;
        end else if (key == KEY_ENTER && digit_cnt == DIGITS) begin
          match = 1'b1;
          for (pos = 0; pos < DIGITS; pos++) begin
            if (code_entry[pos] != lock_cfg.master_code[2*pos +: 2]) begin
              match = 1'b0;
            end
          end
          if (match) begin
            lock_mode   = MODE_OPEN;
            period_left = lock_cfg.open_ticks;
            ir_held     = '0;
            wrong_cnt   = '0;
            ev          = EV_OPENED;
          end else begin
            if (wrong_cnt < WRONG_COUNT_MAX) begin
              wrong_cnt = wrong_cnt + 1'b1;
            end
            digit_cnt = '0;
            ev        = EV_WRONG_CODE;
            if (wrong_cnt >= lock_cfg.wrong_limit) begin
              lock_mode   = MODE_LOCKOUT;
              period_left = lock_cfg.lockout_ticks;
            end
          end
        end
      end else if (lock_mode == MODE_OPEN) begin
        if (period_left == '0) begin
          lock_mode = MODE_LOCKED;
          digit_cnt = '0;
          ev        = EV_CLOSED;
        end else begin
          period_left = period_left - 1'b1;
          if (ir) begin
            // a long enough blockage cuts the open period short
            if (ir_held > lock_cfg.ir_hold_ticks) begin
              period_left = '0;
            end
            ir_held = sat_inc(ir_held);
          end else begin
            ir_held = '0;
          end
        end
      end
    end
    st.door_open       = (lock_mode == MODE_OPEN);
    st.lockout_active  = (lock_mode == MODE_LOCKOUT);
    st.display_on      = awake;
    st.digits_entered  = digit_cnt;
    st.remaining_ticks = (lock_mode == MODE_OPEN || lock_mode == MODE_LOCKOUT) ?
                         period_left : '0;
    st.event_res       = ev;
    return st;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      lock_cfg.master_code   = RST_MASTER_CODE;
      lock_cfg.wrong_limit   = RST_WRONG_LIMIT;
      lock_cfg.lockout_ticks = RST_LOCKOUT_TICKS;
      lock_cfg.open_ticks    = RST_OPEN_TICKS;
      lock_cfg.ir_hold_ticks = RST_IR_HOLD_TICKS;
      lock_cfg.sleep_ticks   = RST_SLEEP_TICKS;
      lock_mode   = MODE_LOCKED;
      code_entry  = '{default: '0};
      digit_cnt   = '0;
      wrong_cnt   = '0;
      period_left = '0;
      ir_held     = '0;
      idle_for    = '0;
      awake       = 1'b1;
      status_due.delete();
      fail_count  = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MASTER_CODE:   lock_cfg.master_code   = cfg_wdata[7:0];
          REG_WRONG_LIMIT:   lock_cfg.wrong_limit   = cfg_wdata[3:0];
          REG_LOCKOUT_TICKS: lock_cfg.lockout_ticks = cfg_wdata[TICKS_W-1:0];
          REG_OPEN_TICKS:    lock_cfg.open_ticks    = cfg_wdata[TICKS_W-1:0];
          REG_IR_HOLD_TICKS: lock_cfg.ir_hold_ticks = cfg_wdata[TICKS_W-1:0];
          REG_SLEEP_TICKS:   lock_cfg.sleep_ticks   = cfg_wdata[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        status_due.push_back(lock_tick(in_data));
      end
      if (out_valid && !out_stall) begin
        if (status_due.size() == 0) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("status beat with nothing due: %h", out_data);
          end
        end else begin
          due = status_due.pop_front();
          if (due.door_open       !== out_data.door_open      ||
              due.lockout_active  !== out_data.lockout_active ||
              due.display_on      !== out_data.display_on     ||
              due.digits_entered  !== out_data.digits_entered ||
              due.remaining_ticks !== out_data.remaining_ticks ||
              due.event_res       !== out_data.event_res) begin
            fail_count++;
            if (fail_count <= REPORT_LIMIT) begin
              $display("status mismatch: open/lockout/disp/digits/left/event exp %0d %0d %0d %0d %0d %0d",
                       due.door_open, due.lockout_active, due.display_on,
                       due.digits_entered, due.remaining_ticks, due.event_res);
              $display("                                                   got %0d %0d %0d %0d %0d %0d",
                       out_data.door_open, out_data.lockout_active, out_data.display_on,
                       out_data.digits_entered, out_data.remaining_ticks, out_data.event_res);
            end
          end
        end
      end
    end
    pending = status_due.size();
  end

endmodule

FILE: test/keypad_code_lock_controller_core_tb.sv
// Top of the keypad code lock bench: clock, reset, tick and register stimulus.
// Depends on kcl_pkg, the lock core and keypad_code_lock_checker.
module keypad_code_lock_controller_core_tb;
  import kcl_pkg::*;

  localparam int unsigned CYCLE_LIMIT      = 1_000_000;
  localparam int unsigned PHASES           = 8;
  localparam int unsigned TICKS_PER_PHASE  = 60;
  localparam int unsigned IDLE_RUN_TICKS   = 20;
  localparam int unsigned SETTLE_CYCLES    = 10;
  localparam logic [2:0]  KEY_SPARE_LO     = 3'd6;
  localparam logic [2:0]  KEY_SPARE_HI     = 3'd7;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [TICKS_W-1:0]     TICKS_MAX    = '1;

  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_data   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned cycles        = 0;
  int unsigned ticks_sent    = 0;
  int unsigned send_idle_pct = 0;
  int unsigned stall_pct     = 0;
  logic [7:0]  code_now      = RST_MASTER_CODE;

  keypad_code_lock_controller_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  keypad_code_lock_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("** keypad_code_lock_controller_core: FAILED **");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Offer one tick beat and hold it until the core takes it.
  task automatic send_tick(input logic [2:0] k, input logic ir);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{key: k, ir_blocked: ir};
    do @(posedge clk); while (in_stall);
    ticks_sent++;
  endtask

  // Drop valid and hold off until every status beat has come back.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Narrow registers get junk in the unused upper bits.
  task automatic set_config(input logic [7:0] code, input logic [3:0] wl,
                            input logic [TICKS_W-1:0] lock_t,
                            input logic [TICKS_W-1:0] open_t,
                            input logic [TICKS_W-1:0] ir_t,
                            input logic [TICKS_W-1:0] sleep_t);
    drain();
    write_reg(REG_MASTER_CODE, {8'($urandom), code});
    write_reg(REG_WRONG_LIMIT, {12'($urandom), wl});
    write_reg(REG_LOCKOUT_TICKS, lock_t);
    write_reg(REG_OPEN_TICKS, open_t);
    write_reg(REG_IR_HOLD_TICKS, ir_t);
    write_reg(REG_SLEEP_TICKS, sleep_t);
    code_now = code;
  endtask

  task automatic enter_code(input logic [7:0] code);
    int pos;
    for (pos = 0; pos < CODE_LENGTH_DEF; pos++) begin
      send_tick(KEY_DIGIT_LO + code[2*pos +: 2], 1'($urandom));
    end
    send_tick(KEY_ENTER, 1'($urandom));
  endtask

  // Mostly code attempts and quiet stretches; a few beats of raw noise.
  task automatic random_burst;
    int unsigned pick;
    int unsigned len;
    logic        ir;
    pick = $urandom_range(99);
    if (pick < 45) begin
      enter_code(code_now);
    end else if (pick < 70) begin
      enter_code(8'($urandom));
    end else if (pick < 85) begin
      len = $urandom_range(30, 1);
      ir  = 1'($urandom);
      repeat (len) send_tick(KEY_NONE, ir);
    end else begin
      len = $urandom_range(5, 1);
      repeat (len) send_tick(3'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int d;
    int unsigned p;
    int unsigned phase_start;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: spare keys, short entry, default code, extra digit
    send_tick(KEY_NONE, 1'b0);
    send_tick(KEY_SPARE_LO, 1'b0);
    send_tick(KEY_SPARE_HI, 1'b1);
    send_tick(KEY_ENTER, 1'b0);
    for (d = 0; d < CODE_LENGTH_DEF; d++) begin
      send_tick(KEY_DIGIT_LO + 3'(d), 1'b0);
    end
    send_tick(KEY_DIGIT_HI, 1'b0);
    send_tick(KEY_ENTER, 1'b0);
    // close early on a held IR blockage
    drain();
    write_reg(REG_IR_HOLD_TICKS, '0);
    send_tick(KEY_NONE, 1'b1);
    send_tick(KEY_NONE, 1'b1);
    send_tick(KEY_NONE, 1'b0);
    // zero wrong limit: first wrong code locks out; lockout ignores keys
    drain();
    write_reg(REG_WRONG_LIMIT, 16'hFFF0);
    write_reg(REG_LOCKOUT_TICKS, 16'd2);
    for (d = 0; d < CODE_LENGTH_DEF; d++) begin
      send_tick(KEY_DIGIT_HI, 1'b0);
    end
    send_tick(KEY_ENTER, 1'b0);
    send_tick(KEY_ENTER, 1'b1);
    send_tick(KEY_DIGIT_LO, 1'b0);
    send_tick(KEY_DIGIT_LO, 1'b1);
    // sleep right away, wake on IR
    drain();
    write_reg(REG_SLEEP_TICKS, '0);
    send_tick(KEY_NONE, 1'b0);
    send_tick(KEY_NONE, 1'b1);

    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: set_config(8'h00, 4'd1, '0, '0, '0, '0);
        1: set_config(8'hFF, 4'd15, 16'd5, 16'd20, 16'd3, 16'd10);
        2: set_config(8'($urandom), 4'd0, 16'd3, TICKS_MAX, 16'd2, TICKS_MAX);
        3: set_config(8'($urandom), 4'd2, 16'd10, 16'd8, TICKS_MAX, 16'd5);
        default: set_config(8'($urandom), 4'($urandom_range(15)),
                            16'($urandom_range(20)), 16'($urandom_range(40)),
                            16'($urandom_range(10)), 16'($urandom_range(30)));
      endcase
      if (p == 3) begin
        // writes to unmapped indexes must not land anywhere
        write_reg(REG_SPARE_LO, 16'($urandom));
        write_reg(REG_SPARE_HI, 16'($urandom));
      end
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 85; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 85; end
        default: begin send_idle_pct = 11; stall_pct = 11; end
      endcase
      phase_start = ticks_sent;
      while (ticks_sent - phase_start < TICKS_PER_PHASE) random_burst();
    end

    // longest sleep setting keeps the display awake through a quiet stretch
    send_idle_pct = 0;
    stall_pct     = 0;
    set_config(code_now, 4'd3, 16'd4, 16'd10, 16'd2, TICKS_MAX);
    repeat (60) send_tick(KEY_NONE, 1'b0);
    send_tick(KEY_NONE, 1'b1);
    repeat (IDLE_RUN_TICKS) send_tick(KEY_NONE, 1'b0);

    // longest lockout: load the full period and feed it ignored beats
    set_config(8'($urandom), 4'd1, TICKS_MAX, 16'd10, 16'd2, 16'd20);
    enter_code(~code_now);
    repeat (200) send_tick(3'($urandom), 1'($urandom));

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("** keypad_code_lock_controller_core: PASSED **");
    end else begin
      $display("** keypad_code_lock_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/kcl_pkg.sv
hdl/kcl_cfg_regs.sv
hdl/kcl_step.sv
hdl/keypad_code_lock_controller_core.sv
test/keypad_code_lock_checker.sv
test/keypad_code_lock_controller_core_tb.sv
